/* sv/ricrc_pkg.sv */
package ricrc_pkg;

  // Reflected CRC-32 constants
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Serial wrap points
  localparam logic [7:0] SERIAL_MAX = 8'hFF;
  localparam logic [7:0] SERIAL_MIN = 8'h00;

  // Copy selection codes
  typedef enum logic [1:0] {
    CHOICE_NONE   = 2'd0,
    CHOICE_FIRST  = 2'd1,
    CHOICE_SECOND = 2'd2
  } choice_e;

  // One input beat
  typedef struct packed {
    logic        copy_sel;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] stored_crc;
    logic [7:0]  serial;
  } item_t;

  // One result beat
  typedef struct packed {
    choice_e choice;
    logic    first_valid;
    logic    second_valid;
  } result_t;

  // Fold one byte into the CRC register, LSB first
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/ricrc_core.sv */
// CRC state, per-copy check and copy selection. State advances on step_i.
module ricrc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ricrc_pkg::item_t    item_i,
  output logic                res_valid_o,
  output ricrc_pkg::result_t  res_o
);

  logic [31:0] crc_q, crc_d;
  logic        first_ok_q, first_ok_d;
  logic [7:0]  first_serial_q, first_serial_d;
  logic [31:0] crc_next;
  logic        ok;

  // CRC of the current byte and the check against the stored word
  assign crc_next = ricrc_pkg::crc_byte(crc_q, item_i.data_byte);
  assign ok       = ((crc_next ^ ricrc_pkg::CRC_ONES) == item_i.stored_crc);

  // A result comes with the last byte of the second copy
  assign res_valid_o = item_i.last_byte && item_i.copy_sel;

  // Copy selection
  always_comb begin
    res_o.first_valid  = first_ok_q;
    res_o.second_valid = ok;
    if (!first_ok_q && !ok) begin
      res_o.choice = ricrc_pkg::CHOICE_NONE;
    end else if (!ok) begin
      res_o.choice = ricrc_pkg::CHOICE_FIRST;
    end else if (!first_ok_q) begin
      res_o.choice = ricrc_pkg::CHOICE_SECOND;
    end else if (first_serial_q == ricrc_pkg::SERIAL_MAX &&
                 item_i.serial == ricrc_pkg::SERIAL_MIN) begin
      res_o.choice = ricrc_pkg::CHOICE_SECOND;
    end else if (item_i.serial == ricrc_pkg::SERIAL_MAX &&
                 first_serial_q == ricrc_pkg::SERIAL_MIN) begin
      res_o.choice = ricrc_pkg::CHOICE_FIRST;
    end else if (item_i.serial > first_serial_q) begin
      res_o.choice = ricrc_pkg::CHOICE_SECOND;
    end else begin
      res_o.choice = ricrc_pkg::CHOICE_FIRST;
    end
  end

  // Next state
  always_comb begin
    crc_d          = crc_q;
    first_ok_d     = first_ok_q;
    first_serial_d = first_serial_q;
    if (step_i) begin
      crc_d = crc_next;
      if (item_i.last_byte) begin
        crc_d = ricrc_pkg::CRC_ONES;
        if (!item_i.copy_sel) begin
          first_ok_d     = ok;
          first_serial_d = item_i.serial;
        end else begin
          first_ok_d     = 1'b0;
          first_serial_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q          <= ricrc_pkg::CRC_ONES;
      first_ok_q     <= 1'b0;
      first_serial_q <= '0;
    end else begin
      crc_q          <= crc_d;
      first_ok_q     <= first_ok_d;
      first_serial_q <= first_serial_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The CRC register is preset after every finished copy
  a_crc_preset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last_byte |=> crc_q == ricrc_pkg::CRC_ONES)
    else $error("CRC register not preset after last byte");

  // First-copy state clears after a result
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o |=> !first_ok_q && first_serial_q == ricrc_pkg::SERIAL_MIN)
    else $error("first copy state not cleared after result");

  // The chosen copy is a valid one, or none when neither copy is valid
  a_choice_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |->
      (res_o.choice == ricrc_pkg::CHOICE_NONE && !res_o.first_valid && !res_o.second_valid) ||
      (res_o.choice == ricrc_pkg::CHOICE_FIRST && res_o.first_valid) ||
      (res_o.choice == ricrc_pkg::CHOICE_SECOND && res_o.second_valid))
    else $error("selected copy is not valid");
`endif

endmodule

/* sv/redundant_image_crc_select.sv */
// Channel | Handshake                  | Payload
// --------+----------------------------+-------------------------------------------
// in      | in_valid_i / in_ready_o    | copy_sel, data_byte, last_byte, stored_crc, serial
// out     | out_valid_o / out_ready_i  | choice, first_valid, second_valid
//
// One byte beat per cycle while no result is held up; a result for the last byte of the
// second copy passes through the input register, then the result register.
// The byte-wide CRC update between the two registers sets the one-cycle rate.
// Reset presets the CRC register to all ones and clears the first-copy result.
// A stalled result holds only the beat that would make a new result; plain bytes
// keep flowing while a result waits.
module redundant_image_crc_select (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        copy_sel_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] stored_crc_i,
  input  logic [7:0]  serial_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  choice_o,
  output logic        first_valid_o,
  output logic        second_valid_o
);

  logic               s1_valid_q, s1_valid_d;
  ricrc_pkg::item_t   s1_item_q;
  logic               out_valid_q, out_valid_d;
  ricrc_pkg::result_t out_q;
  logic               advance;
  logic               res_valid;
  ricrc_pkg::result_t res;

  ricrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (s1_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Stage advances unless its result has nowhere to go
  assign advance    = s1_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  assign s1_valid_d  = (in_valid_i && in_ready_o) || (s1_valid_q && !advance);
  assign out_valid_d = (advance && res_valid) || (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q.copy_sel   <= copy_sel_i;
      s1_item_q.data_byte  <= data_byte_i;
      s1_item_q.last_byte  <= last_byte_i;
      s1_item_q.stored_crc <= stored_crc_i;
      s1_item_q.serial     <= serial_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign choice_o       = out_q.choice;
  assign first_valid_o  = out_q.first_valid;
  assign second_valid_o = out_q.second_valid;

`ifndef NO_ASSERTIONS
  // Input only stalls behind a waiting stage
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && res_valid && out_valid_q && !out_ready_i)
    else $error("input stalled without cause");

  // A result is produced only when the stage steps a second-copy last byte
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(advance && res_valid))
    else $error("result appeared without a source beat");

  // A waiting result is not overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending result lost");
`endif

endmodule

/* bench/tb_redundant_image_crc_select.sv */
`timescale 1ns / 1ps

// Tracks the shared CRC register and the first-copy verdict, and queues the
// copy choice due on each last byte of the second copy.
class image_choice_board;
  logic [31:0]              crc_reg;
  bit                       first_good;
  logic [7:0]               first_ser;
  ricrc_pkg::result_t       due_choices[$];
  int                       errors;

  function new();
    crc_reg    = ricrc_pkg::CRC_ONES;
    first_good = 1'b0;
    first_ser  = '0;
    errors     = 0;
  endfunction

  // Reflected CRC-32, one bit per step, LSB first
  static function logic [31:0] fold(logic [31:0] crc, logic [7:0] data);
    logic [31:0] r;
    r = crc;
    for (int b = 0; b < 8; b++) begin
      r = (r >> 1) ^ (ricrc_pkg::CRC_POLY & {32{r[0] ^ data[b]}});
    end
    return r;
  endfunction

  // CRC the copy would end with if this data byte closed it
  function logic [31:0] closing_crc(logic [7:0] data);
    return fold(crc_reg, data) ^ ricrc_pkg::CRC_ONES;
  endfunction

  // Which copy to boot from; serial 0 beats 255, ties go to the first copy
  static function ricrc_pkg::choice_e rank_copies(bit ok1, bit ok2,
                                                  logic [7:0] s1, logic [7:0] s2);
    if (!ok1 && !ok2) return ricrc_pkg::CHOICE_NONE;
    if (!ok2) return ricrc_pkg::CHOICE_FIRST;
    if (!ok1) return ricrc_pkg::CHOICE_SECOND;
    if (s1 == ricrc_pkg::SERIAL_MAX && s2 == ricrc_pkg::SERIAL_MIN)
      return ricrc_pkg::CHOICE_SECOND;
    if (s2 == ricrc_pkg::SERIAL_MAX && s1 == ricrc_pkg::SERIAL_MIN)
      return ricrc_pkg::CHOICE_FIRST;
    if (s2 > s1) return ricrc_pkg::CHOICE_SECOND;
    return ricrc_pkg::CHOICE_FIRST;
  endfunction

  // Accepted input beat
  function void note_byte(ricrc_pkg::item_t it);
    bit                 ok;
    ricrc_pkg::result_t res;
    ok      = (closing_crc(it.data_byte) == it.stored_crc);
    crc_reg = fold(crc_reg, it.data_byte);
    if (it.last_byte) begin
      crc_reg = ricrc_pkg::CRC_ONES;
      if (!it.copy_sel) begin
        first_good = ok;
        first_ser  = it.serial;
      end else begin
        res.choice       = rank_copies(first_good, ok, first_ser, it.serial);
        res.first_valid  = first_good;
        res.second_valid = ok;
        due_choices.push_back(res);
        first_good = 1'b0;
        first_ser  = '0;
      end
    end
  endfunction

  // Accepted result beat
  function void check_choice(logic [1:0] ch, logic fv, logic sv);
    ricrc_pkg::result_t want;
    if (due_choices.size() == 0) begin
      $error("result beat with no choice due: choice %0d", ch);
      errors++;
      return;
    end
    want = due_choices.pop_front();
    if (ch !== want.choice) begin
      $error("choice: expected %0d, got %0d", want.choice, ch);
      errors++;
    end
    if (fv !== want.first_valid) begin
      $error("first_valid: expected %0d, got %0d", want.first_valid, fv);
      errors++;
    end
    if (sv !== want.second_valid) begin
      $error("second_valid: expected %0d, got %0d", want.second_valid, sv);
      errors++;
    end
  endfunction
endclass

module tb_redundant_image_crc_select;

  localparam int DIRECTED_BEATS = 23;
  localparam int PHASE_BEATS    = 400;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        copy_sel_i     = 1'b0;
  logic [7:0]  data_byte_i    = '0;
  logic        last_byte_i    = 1'b0;
  logic [31:0] stored_crc_i   = '0;
  logic [7:0]  serial_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [1:0]  choice_o;
  logic        first_valid_o;
  logic        second_valid_o;

  int tx_idle_pct = 24;
  int rx_idle_pct = 78;
  int beats_sent  = 0;

  image_choice_board board = new();

  redundant_image_crc_select dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .copy_sel_i     (copy_sel_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .stored_crc_i   (stored_crc_i),
    .serial_i       (serial_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .choice_o       (choice_o),
    .first_valid_o  (first_valid_o),
    .second_valid_o (second_valid_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: random stalls, check every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        board.check_choice(choice_o, first_valid_o, second_valid_o);
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Drive one byte beat and hold it until taken
  task automatic push(input logic sel, input logic [7:0] data, input logic last,
                      input logic [31:0] crc, input logic [7:0] ser);
    ricrc_pkg::item_t it;
    it.copy_sel   = sel;
    it.data_byte  = data;
    it.last_byte  = last;
    it.stored_crc = crc;
    it.serial     = ser;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    copy_sel_i   <= sel;
    data_byte_i  <= data;
    last_byte_i  <= last;
    stored_crc_i <= crc;
    serial_i     <= ser;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(it);
    beats_sent++;
  endtask

  // One copy of n bytes; mix scatters copy_sel over the bytes before the last
  task automatic copy_image(input logic sel, input int n, input bit good,
                            input logic [7:0] ser, input bit mix);
    logic [7:0]  data;
    logic [31:0] flip;
    for (int i = 0; i < n - 1; i++) begin
      push(mix ? 1'($urandom) : sel, 8'($urandom), 1'b0, $urandom, 8'($urandom));
    end
    data = 8'($urandom);
    flip = $urandom;
    if (flip == 0) flip = 32'h1;
    push(sel, data, 1'b1, board.closing_crc(data) ^ (good ? 32'h0 : flip), ser);
  endtask

  // Sender holds off until every due choice has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.due_choices.size() != 0);
  endtask

  function automatic logic [7:0] pick_serial(logic [7:0] other);
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      return ($urandom_range(1) != 0) ? ricrc_pkg::SERIAL_MAX : ricrc_pkg::SERIAL_MIN;
    end
    if (r < 40) return other;
    return 8'($urandom);
  endfunction

  function automatic int pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
  endfunction

  // Mostly well-formed image pairs, some broken orders, some noise
  task automatic random_step();
    int         r;
    logic [7:0] s1;
    logic [7:0] s2;
    r  = $urandom_range(99);
    s1 = pick_serial(8'($urandom));
    s2 = pick_serial(s1);
    if (r < 75) begin
      copy_image(1'b0, pick_len(), $urandom_range(3) != 0, s1, 1'b0);
      copy_image(1'b1, pick_len(), $urandom_range(3) != 0, s2, 1'b0);
    end else if (r < 80) begin
      copy_image(1'b0, pick_len(), $urandom_range(3) != 0, s1, 1'b1);
      copy_image(1'b1, pick_len(), $urandom_range(3) != 0, s2, 1'b1);
    end else if (r < 85) begin
      copy_image(1'b1, pick_len(), $urandom_range(1) != 0, s2, 1'b0);
    end else if (r < 90) begin
      copy_image(1'b0, pick_len(), $urandom_range(1) != 0, s1, 1'b0);
      copy_image(1'b0, pick_len(), $urandom_range(1) != 0, s2, 1'b0);
    end else begin
      push(1'($urandom), 8'($urandom), 1'($urandom), $urandom, 8'($urandom));
    end
  endtask

  // Main sequence
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Second copy with no first copy finished
    copy_image(1'b1, 1, 1'b1, ricrc_pkg::SERIAL_MIN, 1'b0);
    // Both bad, field extremes
    push(1'b0, 8'hFF, 1'b1, 32'hFFFF_FFFF, ricrc_pkg::SERIAL_MAX);
    push(1'b1, 8'h00, 1'b1, 32'h0000_0000, ricrc_pkg::SERIAL_MIN);
    // Serial wrap both ways
    copy_image(1'b0, 1, 1'b1, ricrc_pkg::SERIAL_MAX, 1'b0);
    copy_image(1'b1, 1, 1'b1, ricrc_pkg::SERIAL_MIN, 1'b0);
    copy_image(1'b0, 2, 1'b1, ricrc_pkg::SERIAL_MIN, 1'b0);
    copy_image(1'b1, 1, 1'b1, ricrc_pkg::SERIAL_MAX, 1'b0);
    // Tie, then first higher
    copy_image(1'b0, 1, 1'b1, 8'd77, 1'b0);
    copy_image(1'b1, 1, 1'b1, 8'd77, 1'b0);
    copy_image(1'b0, 1, 1'b1, 8'd200, 1'b0);
    copy_image(1'b1, 1, 1'b1, 8'd100, 1'b0);
    // Only the first copy good
    copy_image(1'b0, 1, 1'b1, 8'd3, 1'b0);
    copy_image(1'b1, 1, 1'b0, 8'd9, 1'b0);
    // First copy finished twice, the later verdict stands
    copy_image(1'b0, 1, 1'b0, 8'd9, 1'b0);
    copy_image(1'b0, 1, 1'b1, 8'd10, 1'b0);
    copy_image(1'b1, 1, 1'b1, 8'd5, 1'b0);
    // Interleaved copy_sel on the body bytes
    copy_image(1'b0, 3, 1'b1, 8'd1, 1'b1);
    copy_image(1'b1, 3, 1'b1, 8'd2, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 78 : 0;
      rx_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 24 : 0;
      while (beats_sent < DIRECTED_BEATS + (ph + 1) * PHASE_BEATS) random_step();
      if (ph == 1) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("[redundant_image_crc_select] OK");
    end else begin
      $display("[redundant_image_crc_select] ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("[redundant_image_crc_select] ERROR");
    $finish;
  end

endmodule

/* redundant_image_crc_select.f */
sv/ricrc_pkg.sv
sv/ricrc_core.sv
sv/redundant_image_crc_select.sv
bench/tb_redundant_image_crc_select.sv
